[sv/ppg_pkg.sv]
// shared types, constants and the sine table generator of the plasma pixel generator
`default_nettype none

package ppg_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y = 2'd1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [7:0] CENTER_X_RESET = 8'd80;
   localparam logic [7:0] CENTER_Y_RESET = 8'd72;

   // default quarter-wave table resolution
   localparam int unsigned SINE_TABLE_BITS_DEF = 10;

   // phase step per frame, dot scale and radial scale in turn units
   localparam logic [20:0] PHASE_K = 21'd2050696;
   localparam logic [15:0] DOT_K   = 16'd53404;
   localparam logic [16:0] RAD_K   = 17'd80105;

   // squared distance and its root
   localparam int unsigned ROOT_W = 25;
   localparam int unsigned SQ_W   = 2 * ROOT_W;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   typedef struct packed {
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [23:0] frame_time;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // one entry of the quarter-wave table, taylor series in q30, rounded to q15
   function automatic logic [14:0] sine_entry(input int unsigned idx, input int unsigned bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned p;
      longint unsigned s;
      int k;
      x  = (64'(idx) * HALF_PI_Q30) >> bits;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (k = 0; k < 5; k++) begin
         case (k)
            0: p = ((x2 * t) >> 30) / 110;
            1: p = ((x2 * t) >> 30) / 72;
            2: p = ((x2 * t) >> 30) / 42;
            3: p = ((x2 * t) >> 30) / 20;
            default: p = ((x2 * t) >> 30) / 6;
         endcase
         t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
      end
      s = (((x * t) >> 30) + 64'd16384) >> 15;
      return (s > 64'd32767) ? 15'h7FFF : s[14:0];
   endfunction

endpackage

`default_nettype wire

[sv/plasma_pixel_generator.sv]
// top level of the plasma pixel generator: one plasma colour per pixel transaction
`default_nettype none

// plasma pixel generator. each request transaction carries a pixel coordinate and a
// frame counter and yields one response transaction with the red, green and blue bytes
// of the plasma colour for that pixel. the block is a fully pipelined datapath: a new
// pixel is taken on every clock cycle unless the response side stalls, so the
// sustained rate is one pixel per cycle. the square root of the squared distance is
// solved one root bit per stage; the other stages hold the phase multiply, three sine
// rom lookups (each with a registered read), the distance products, the averaging of
// the two terms and the scaling of each colour channel. every stage has its own
// valid bit and moves on whenever the stage after it is free, so bubbles close up and
// a stalled response holds the pipeline without losing or repeating a pixel. the
// centre registers are written through the csr port and must only change while no
// pixel is in flight; coordinates outside the picture are computed like any other.

module plasma_pixel_generator
   import ppg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned RB = ROOT_W;
   localparam int unsigned RW = ROOT_W + 2;

   // what rides along the square root stages
   typedef struct packed {
      logic [15:0]        phi;
      logic signed [15:0] s3;
      logic [15:0]        a1;
   } ctx_type;

   // byte from a scaled value p = (s + 32767) * 255, divided by 65534
   function automatic logic [7:0] to_byte(input logic [23:0] p);
      logic [7:0]  q;
      logic [16:0] r;
      q = p[23:16];
      r = {1'b0, p[15:0]} + {8'd0, q, 1'b0};
      return (r >= 17'd65534) ? q + 8'd1 : q;
   endfunction

   // centre registers
   logic [7:0] cx_ff;
   logic [7:0] cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= CENTER_X_RESET;
         cy_ff <= CENTER_Y_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_CENTER_X: cx_ff <= csr_wdata;
            REG_CENTER_Y: cy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;
   logic rsp_valid_ff;
   logic e1, e2, e3, e4, e5, e6, e7, e8, e9, e10, e11, e12;
   logic q_v_ff [RB];
   logic q_en   [RB];

   assign e12 = !rsp_valid_ff || rsp_ready;
   assign e11 = !v11_ff || e12;
   assign e10 = !v10_ff || e11;
   assign e9  = !v9_ff  || e10;
   assign e8  = !v8_ff  || e9;
   assign e7  = !v7_ff  || e8;
   assign e6  = !v6_ff  || q_en[0];
   assign e5  = !v5_ff  || e6;
   assign e4  = !v4_ff  || e5;
   assign e3  = !v3_ff  || e4;
   assign e2  = !v2_ff  || e3;
   assign e1  = !v1_ff  || e2;

   assign req_ready = e1;
   assign rsp_valid = rsp_valid_ff;

   // stage 1: frame phase
   logic [44:0] phase_prod;
   logic [7:0]  r1_x_ff, r1_y_ff;
   logic [15:0] r1_phi_ff;

   assign phase_prod = 45'(req_data.frame_time) * 45'(PHASE_K);

   always_ff @(posedge clock) begin
      if (e1) begin
         r1_x_ff   <= req_data.pixel_x;
         r1_y_ff   <= req_data.pixel_y;
         r1_phi_ff <= phase_prod[31:16];
      end
   end

   // stage 2: sine and cosine of the phase
   logic signed [15:0] s3, c3;
   logic [7:0]         r2_x_ff, r2_y_ff;
   logic [15:0]        r2_phi_ff;

   ppg_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_phase (
      .clock   (clock),
      .enable  (e2),
      .angle_a (r1_phi_ff),
      .angle_b (r1_phi_ff + 16'd16384),
      .sine_a  (s3),
      .sine_b  (c3)
   );

   always_ff @(posedge clock) begin
      if (e2) begin
         r2_x_ff   <= r1_x_ff;
         r2_y_ff   <= r1_y_ff;
         r2_phi_ff <= r1_phi_ff;
      end
   end

   // stage 3: products with the rotating vector and orbit radii
   logic signed [24:0] s3_ext, c3_ext;
   logic signed [24:0] px_in, py_in, ms3_in, mc3_in;
   logic signed [24:0] r3_px_ff, r3_py_ff, r3_ms3_ff, r3_mc3_ff;
   logic [7:0]         r3_x_ff, r3_y_ff;
   logic [15:0]        r3_phi_ff;
   logic signed [15:0] r3_s3_ff;

   assign s3_ext = {{9{s3[15]}}, s3};
   assign c3_ext = {{9{c3[15]}}, c3};
   assign px_in  = $signed({17'd0, r2_x_ff}) * s3_ext;
   assign py_in  = $signed({17'd0, r2_y_ff}) * c3_ext;
   assign ms3_in = $signed({17'd0, cx_ff}) * s3_ext;
   assign mc3_in = $signed({17'd0, cy_ff}) * c3_ext;

   always_ff @(posedge clock) begin
      if (e3) begin
         r3_px_ff  <= px_in;
         r3_py_ff  <= py_in;
         r3_ms3_ff <= ms3_in;
         r3_mc3_ff <= mc3_in;
         r3_x_ff   <= r2_x_ff;
         r3_y_ff   <= r2_y_ff;
         r3_phi_ff <= r2_phi_ff;
         r3_s3_ff  <= s3;
      end
   end

   // stage 4: dot product and offsets from the orbiting centre
   logic signed [24:0] xo, yo;
   logic signed [24:0] r4_dot_ff, r4_dx_ff, r4_dy_ff;
   logic [15:0]        r4_phi_ff;
   logic signed [15:0] r4_s3_ff;

   assign xo = $signed({17'd0, r3_x_ff}) - $signed({17'd0, cx_ff});
   assign yo = $signed({17'd0, r3_y_ff}) - $signed({17'd0, cy_ff});

   always_ff @(posedge clock) begin
      if (e4) begin
         r4_dot_ff <= r3_px_ff + r3_py_ff;
         r4_dx_ff  <= (xo <<< 15) + r3_ms3_ff;
         r4_dy_ff  <= (yo <<< 15) - r3_mc3_ff;
         r4_phi_ff <= r3_phi_ff;
         r4_s3_ff  <= r3_s3_ff;
      end
   end

   // stage 5: scaled dot and squares
   logic [23:0]        ax, ay;
   logic signed [40:0] dotk_in;
   logic signed [40:0] r5_dotk_ff;
   logic [47:0]        r5_ax2_ff, r5_ay2_ff;
   logic [15:0]        r5_phi_ff;
   logic signed [15:0] r5_s3_ff;

   assign ax      = r4_dx_ff[24] ? 24'(-r4_dx_ff) : r4_dx_ff[23:0];
   assign ay      = r4_dy_ff[24] ? 24'(-r4_dy_ff) : r4_dy_ff[23:0];
   assign dotk_in = {{16{r4_dot_ff[24]}}, r4_dot_ff} * $signed({25'd0, DOT_K});

   always_ff @(posedge clock) begin
      if (e5) begin
         r5_dotk_ff <= dotk_in;
         r5_ax2_ff  <= 48'(ax) * 48'(ax);
         r5_ay2_ff  <= 48'(ay) * 48'(ay);
         r5_phi_ff  <= r4_phi_ff;
         r5_s3_ff   <= r4_s3_ff;
      end
   end

   // stage 6: first angle and squared distance
   logic [SQ_W-1:0] r6_sq_ff;
   ctx_type         r6_ctx_ff;

   always_ff @(posedge clock) begin
      if (e6) begin
         r6_sq_ff      <= {2'b00, r5_ax2_ff} + {2'b00, r5_ay2_ff};
         r6_ctx_ff.phi <= r5_phi_ff;
         r6_ctx_ff.s3  <= r5_s3_ff;
         r6_ctx_ff.a1  <= r5_dotk_ff[38:23] + r5_phi_ff;
      end
   end

   // square root, one root bit per stage
   logic [RW-1:0]   q_rem_ff  [RB];
   logic [RB-1:0]   q_root_ff [RB];
   logic [SQ_W-1:0] q_val_ff  [RB];
   ctx_type         q_ctx_ff  [RB];

   genvar j;
   for (j = 0; j < RB; j++) begin : g_sqrt
      logic [RW-1:0]   rem_prev, rem_sh, trial;
      logic [RB-1:0]   root_prev;
      logic [SQ_W-1:0] val_prev;
      ctx_type         ctx_prev;
      logic            v_prev;
      logic            take;

      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = r6_sq_ff;
         assign ctx_prev  = r6_ctx_ff;
         assign v_prev    = v6_ff;
      end else begin : g_next
         assign rem_prev  = q_rem_ff[j-1];
         assign root_prev = q_root_ff[j-1];
         assign val_prev  = q_val_ff[j-1];
         assign ctx_prev  = q_ctx_ff[j-1];
         assign v_prev    = q_v_ff[j-1];
      end

      if (j == RB - 1) begin : g_last
         assign q_en[j] = !q_v_ff[j] || e7;
      end else begin : g_mid
         assign q_en[j] = !q_v_ff[j] || q_en[j+1];
      end

      assign rem_sh = {rem_prev[RW-3:0], val_prev[SQ_W-1 -: 2]};
      assign trial  = {root_prev, 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (q_en[j]) begin
            q_rem_ff[j]  <= take ? rem_sh - trial : rem_sh;
            q_root_ff[j] <= {root_prev[RB-2:0], take};
            q_val_ff[j]  <= {val_prev[SQ_W-3:0], 2'b00};
            q_ctx_ff[j]  <= ctx_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            q_v_ff[j] <= 1'b0;
         end else if (q_en[j]) begin
            q_v_ff[j] <= v_prev;
         end
      end
   end

   // stage 7: radial angle
   logic [41:0] a2_prod;
   logic [15:0] r7_a2_ff;
   ctx_type     r7_ctx_ff;

   assign a2_prod = 42'(q_root_ff[RB-1]) * 42'(RAD_K);

   always_ff @(posedge clock) begin
      if (e7) begin
         r7_a2_ff  <= a2_prod[38:23];
         r7_ctx_ff <= q_ctx_ff[RB-1];
      end
   end

   // stage 8: both terms from the rom
   logic signed [15:0] s1, s2;
   logic [15:0]        r8_phi_ff;
   logic signed [15:0] r8_s3_ff;

   ppg_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_terms (
      .clock   (clock),
      .enable  (e8),
      .angle_a (r7_ctx_ff.a1),
      .angle_b (r7_a2_ff + 16'd16384),
      .sine_a  (s1),
      .sine_b  (s2)
   );

   always_ff @(posedge clock) begin
      if (e8) begin
         r8_phi_ff <= r7_ctx_ff.phi;
         r8_s3_ff  <= r7_ctx_ff.s3;
      end
   end

   // stage 9: average of the two half terms, colour angle
   logic [14:0]        h1, h2, m;
   logic [15:0]        hsum;
   logic [15:0]        r9_am_ff;
   logic signed [15:0] r9_s3_ff;

   // s + 32768 is the sign bit flipped
   assign h1   = {~s1[15], s1[14:1]};
   assign h2   = {~s2[15], s2[14:1]};
   assign hsum = {1'b0, h1} + {1'b0, h2};
   assign m    = hsum[15:1];

   always_ff @(posedge clock) begin
      if (e9) begin
         r9_am_ff <= {m, 1'b0} + r8_phi_ff;
         r9_s3_ff <= r8_s3_ff;
      end
   end

   // stage 10: cosine and sine of the colour angle
   logic signed [15:0] cr, sg;
   logic signed [15:0] r10_s3_ff;

   ppg_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_colour (
      .clock   (clock),
      .enable  (e10),
      .angle_a (r9_am_ff + 16'd16384),
      .angle_b (r9_am_ff),
      .sine_a  (cr),
      .sine_b  (sg)
   );

   always_ff @(posedge clock) begin
      if (e10) begin
         r10_s3_ff <= r9_s3_ff;
      end
   end

   // stage 11: scale each channel by 255
   logic [15:0] ur, ug, ub;
   logic [23:0] r11_pr_ff, r11_pg_ff, r11_pb_ff;

   assign ur = cr + 16'd32767;
   assign ug = sg + 16'd32767;
   assign ub = r10_s3_ff + 16'd32767;

   always_ff @(posedge clock) begin
      if (e11) begin
         r11_pr_ff <= {ur, 8'd0} - {8'd0, ur};
         r11_pg_ff <= {ug, 8'd0} - {8'd0, ug};
         r11_pb_ff <= {ub, 8'd0} - {8'd0, ub};
      end
   end

   // stage 12: divide by 65534, output register
   always_ff @(posedge clock) begin
      if (e12) begin
         rsp_data.red   <= to_byte(r11_pr_ff);
         rsp_data.green <= to_byte(r11_pg_ff);
         rsp_data.blue  <= to_byte(r11_pb_ff);
      end
   end

   // valid bits of the fixed stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (e1)  v1_ff        <= req_valid;
         if (e2)  v2_ff        <= v1_ff;
         if (e3)  v3_ff        <= v2_ff;
         if (e4)  v4_ff        <= v3_ff;
         if (e5)  v5_ff        <= v4_ff;
         if (e6)  v6_ff        <= v5_ff;
         if (e7)  v7_ff        <= q_v_ff[RB-1];
         if (e8)  v8_ff        <= v7_ff;
         if (e9)  v9_ff        <= v8_ff;
         if (e10) v10_ff       <= v9_ff;
         if (e11) v11_ff       <= v10_ff;
         if (e12) rsp_valid_ff <= v11_ff;
      end
   end

`ifndef ASSERT_OFF
   // no response is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // with the output register free the whole pipeline can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with an empty output register");

   // a stage held by a stalled output keeps its pixel
   a_hold_last_stage: assert property (@(posedge clock) disable iff (reset)
      (v11_ff && !e12) |=> (v11_ff && $stable(r11_pr_ff) && $stable(r11_pg_ff)
                             && $stable(r11_pb_ff)))
      else $error("scaled pixel lost under stall");

   // a stalled first stage keeps both its pixel and the phase
   a_hold_first_stage: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !e2) |=> (v1_ff && $stable(r1_phi_ff) && $stable(r1_x_ff)))
      else $error("first stage changed under stall");
`endif

endmodule

`default_nettype wire

[sv/ppg_sine_rom.sv]
// quarter-wave sine rom with two registered read ports and quadrant folding
`default_nettype none

module ppg_sine_rom
   import ppg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic [15:0]        angle_a,
   input  wire logic [15:0]        angle_b,
   output logic signed [15:0]      sine_a,
   output logic signed [15:0]      sine_b
);

   localparam int unsigned N = 1 << SINE_TABLE_BITS;
   localparam int unsigned IDX_W = SINE_TABLE_BITS + 1;

   logic [14:0] rom [0:N];

   genvar i;
   for (i = 0; i <= N; i++) begin : g_rom
      localparam logic [14:0] ENTRY = sine_entry(i, SINE_TABLE_BITS);
      assign rom[i] = ENTRY;
   end

   logic [IDX_W-1:0] idx_a;
   logic [IDX_W-1:0] idx_b;
   logic [14:0]      val_a_ff;
   logic [14:0]      val_b_ff;
   logic             neg_a_ff;
   logic             neg_b_ff;

   // odd quadrants read the table backwards
   assign idx_a = angle_a[14]
      ? IDX_W'(N) - {1'b0, angle_a[13 -: SINE_TABLE_BITS]}
      : {1'b0, angle_a[13 -: SINE_TABLE_BITS]};
   assign idx_b = angle_b[14]
      ? IDX_W'(N) - {1'b0, angle_b[13 -: SINE_TABLE_BITS]}
      : {1'b0, angle_b[13 -: SINE_TABLE_BITS]};

   always_ff @(posedge clock) begin
      if (enable) begin
         val_a_ff <= rom[idx_a];
         val_b_ff <= rom[idx_b];
         neg_a_ff <= angle_a[15];
         neg_b_ff <= angle_b[15];
      end
   end

   assign sine_a = neg_a_ff ? -$signed({1'b0, val_a_ff}) : $signed({1'b0, val_a_ff});
   assign sine_b = neg_b_ff ? -$signed({1'b0, val_b_ff}) : $signed({1'b0, val_b_ff});

endmodule

`default_nettype wire

[bench/testbench.sv]
// self-checking testbench of the plasma pixel generator
`timescale 1ns / 1ps

module testbench;
   import ppg_pkg::*;

   localparam int unsigned TBL_BITS = SINE_TABLE_BITS_DEF;
   localparam int unsigned TBL_N = 1 << TBL_BITS;
   // pipeline depth is 37, allow some margin after the last response
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   plasma_pixel_generator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state: own copy of the centre registers and the quarter-wave table
   int          quarter_wave [TBL_N+1];
   logic [7:0]  centre_x;
   logic [7:0]  centre_y;

   req_type     pending_pixels [$];
   rsp_type     expected_colours [$];
   int          error_count;
   int          cycle_count;
   int          colours_seen;
   bit          steady_flow;   // no idling on either side while set
   bit          long_hold_done;
   int          hold_cycles;

   // clock generation
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // quarter-wave entry by a taylor series in q30, rounded to q15
   function automatic int quarter_sine(input int unsigned idx);
      longint unsigned ang, ang2, acc, prod, res;
      longint unsigned denoms [5];
      int k;
      denoms = '{110, 72, 42, 20, 6};
      ang  = (longint'(idx) * 64'd1686629713) >> TBL_BITS;
      ang2 = (ang * ang) >> 30;
      acc  = 64'd1 << 30;
      for (k = 0; k < 5; k++) begin
         prod = ((ang2 * acc) >> 30) / denoms[k];
         acc  = (prod >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - prod;
      end
      res = (((ang * acc) >> 30) + 64'd16384) >> 15;
      return (res > 64'd32767) ? 32767 : int'(res);
   endfunction

   // sine of a 16-bit turn angle, q15
   function automatic int wave_sin(input logic [15:0] angle);
      int mag;
      logic [TBL_BITS-1:0] slot;
      slot = angle[13:14-TBL_BITS];
      mag = angle[14] ? quarter_wave[TBL_N - slot] : quarter_wave[slot];
      return angle[15] ? -mag : mag;
   endfunction

   function automatic int wave_cos(input logic [15:0] angle);
      return wave_sin(angle + 16'd16384);
   endfunction

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned root, bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   function automatic logic [7:0] to_byte(input int s);
      longint unsigned wide;
      wide = (longint'(s + 32767) * 255) / 65534;
      return wide[7:0];
   endfunction

   // expected colour of one pixel under the current centre registers
   function automatic rsp_type plasma_colour(input req_type px);
      rsp_type col;
      logic [15:0] phase, ang1, ang2, ang_mix;
      longint unsigned ph_wide, root_dist, sum_sq;
      longint px_x, px_y, dotp, dx, dy, dot_scaled;
      int s_ph, c_ph, term1, term2;
      int unsigned half1, half2, mix;
      px_x = longint'(px.pixel_x);
      px_y = longint'(px.pixel_y);
      ph_wide = (longint'(px.frame_time) * 64'd2050696) >> 16;
      phase = ph_wide[15:0];
      s_ph = wave_sin(phase);
      c_ph = wave_cos(phase);
      // rotating vector term
      dotp = px_x * s_ph + px_y * c_ph;
      dot_scaled = dotp * 53404;
      ang1 = 16'(longint'($unsigned(dot_scaled) >> 23)) + phase;
      term1 = wave_sin(ang1);
      // radial term around the orbiting centre
      dx = px_x * 32768 - (longint'(centre_x) * 32768 - longint'(centre_x) * s_ph);
      dy = px_y * 32768 - (longint'(centre_y) * 32768 + longint'(centre_y) * c_ph);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sum_sq = longint'(dx * dx) + longint'(dy * dy);
      root_dist = int_root(sum_sq);
      ang2 = 16'((root_dist * 64'd80105) >> 23);
      term2 = wave_cos(ang2);
      half1 = int'(unsigned'(term1 + 32768)) >> 1;
      half2 = int'(unsigned'(term2 + 32768)) >> 1;
      mix = (half1 + half2) >> 1;
      ang_mix = 16'(mix << 1) + phase;
      col.red   = to_byte(wave_cos(ang_mix));
      col.green = to_byte(wave_sin(ang_mix));
      col.blue  = to_byte(s_ph);
      return col;
   endfunction

   // request driver: fed from the pending queue, predicts on every accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready)
            expected_colours.push_back(plasma_colour(req_data));
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() > 0 && (steady_flow || $urandom_range(99) >= 31)) begin
               req_valid <= 1'b1;
               req_data  <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side: random back-pressure plus one long hold-off to fill the pipeline
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         hold_cycles    <= 0;
         long_hold_done <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (!long_hold_done && colours_seen >= 200) begin
         long_hold_done <= 1'b1;
         hold_cycles    <= 300;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= steady_flow || ($urandom_range(99) >= 31);
      end
   end

   // response monitor: compare against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         colours_seen <= colours_seen + 1;
         if (expected_colours.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type exp_col;
            exp_col = expected_colours.pop_front();
            if (rsp_data.red !== exp_col.red)
               $display("%0t: red expected %0d actual %0d", $time, exp_col.red, rsp_data.red);
            if (rsp_data.green !== exp_col.green)
               $display("%0t: green expected %0d actual %0d", $time, exp_col.green,
                        rsp_data.green);
            if (rsp_data.blue !== exp_col.blue)
               $display("%0t: blue expected %0d actual %0d", $time, exp_col.blue,
                        rsp_data.blue);
            if (rsp_data !== exp_col) error_count++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[plasma_pixel_generator] ERROR");
         $finish;
      end
   end

   task automatic queue_pixel(input logic [7:0] px, input logic [7:0] py,
                              input logic [23:0] ft);
      req_type item;
      item.pixel_x = px;
      item.pixel_y = py;
      item.frame_time = ft;
      pending_pixels.push_back(item);
   endtask

   // wait until every queued pixel is out and every colour is back, then the drain time
   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req_valid || expected_colours.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // the write enable stays high between back-to-back writes
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == REG_CENTER_X) centre_x = val;
      else if (idx == REG_CENTER_Y) centre_y = val;
   endtask

   // mostly in-picture pixels, some anywhere in the 8-bit range
   task automatic queue_random(input int count);
      repeat (count) begin
         if ($urandom_range(9) < 8)
            queue_pixel(8'($urandom_range(159)), 8'($urandom_range(143)), 24'($urandom));
         else
            queue_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 24'($urandom));
      end
   endtask

   initial begin
      int phase_no;
      for (int i = 0; i <= TBL_N; i++) quarter_wave[i] = quarter_sine(i);
      centre_x = CENTER_X_RESET;
      centre_y = CENTER_Y_RESET;
      error_count  = 0;
      cycle_count  = 0;
      colours_seen = 0;
      steady_flow  = 1'b0;
      csr_we    = 1'b0;
      csr_index = REG_CENTER_X;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, out-of-picture pixels, frame counter extremes, reset centre
      queue_pixel(0, 0, 0);
      queue_pixel(159, 143, 0);
      queue_pixel(255, 255, 24'hFFFFFF);
      queue_pixel(160, 0, 24'h000001);
      queue_pixel(0, 144, 24'h800000);
      queue_pixel(80, 72, 24'h7FFFFF);
      queue_pixel(8'hAA, 8'h55, 24'hAAAAAA);
      queue_pixel(8'h55, 8'hAA, 24'h555555);
      queue_pixel(255, 0, 24'd523);
      queue_pixel(0, 255, 24'd1047);
      wait_idle();

      // several centre settings, extremes included, plus writes to unused indexes
      for (phase_no = 0; phase_no < 7; phase_no++) begin
         case (phase_no)
            0: begin write_reg(REG_CENTER_X, 8'd0);   write_reg(REG_CENTER_Y, 8'd0);   end
            1: begin write_reg(REG_CENTER_X, 8'd255); write_reg(REG_CENTER_Y, 8'd255); end
            2: begin write_reg(REG_CENTER_X, 8'd0);   write_reg(REG_CENTER_Y, 8'd255); end
            3: begin
               write_reg(REG_CENTER_X, 8'd80);
               write_reg(REG_CENTER_Y, 8'd72);
               write_reg(2'd2, 8'hFF);   // unknown index, ignored
               write_reg(2'd3, 8'h11);
            end
            default: begin
               write_reg(REG_CENTER_X, 8'($urandom_range(255)));
               write_reg(REG_CENTER_Y, 8'($urandom_range(255)));
            end
         endcase
         csr_we <= 1'b0;
         if (phase_no < 3) begin
            queue_pixel(0, 0, 24'hFFFFFF);
            queue_pixel(255, 255, 0);
            queue_random(40);
         end else begin
            // long stretch with no idling on phase 4
            steady_flow = (phase_no == 4);
            queue_random(330);
         end
         // sender pauses until every colour has come back
         wait_idle();
         steady_flow = 1'b0;
      end

      if (error_count == 0) begin
         $display("[plasma_pixel_generator] OK");
      end else begin
         $display("[plasma_pixel_generator] ERROR");
      end
      $finish;
   end

endmodule
